### hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms for the mapping table blocks
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define VMRMT_ASSERT_IMPL(lbl, clk, rst_n, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("assertion failed");

// next-cycle implication
`define VMRMT_ASSERT_NEXT(lbl, clk, rst_n, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("assertion failed");

`endif

### hdl/vmrmt_pkg.sv
// ----------------------------------------------------------------------------
// vmrmt_pkg
// types, codes and reset values of the region mapping table
// ----------------------------------------------------------------------------
package vmrmt_pkg;

    localparam int unsigned DW        = 32;
    localparam int unsigned ALW       = 5;
    localparam int unsigned CFG_IDX_W = 4;

    typedef logic [1:0]           t_func;
    typedef logic [1:0]           t_status;
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    localparam t_func FN_MAP    = 2'd0;
    localparam t_func FN_UNMAP  = 2'd1;
    localparam t_func FN_APPEND = 2'd2;
    localparam t_func FN_RETURN = 2'd3;

    localparam t_status ST_OK    = 2'd0;
    localparam t_status ST_INVAL = 2'd1;
    localparam t_status ST_NOMEM = 2'd2;

    localparam t_cfg_idx CFG_WIN_BASE = 4'd0;
    localparam t_cfg_idx CFG_WIN_END  = 4'd1;
    localparam t_cfg_idx CFG_VALIGN   = 4'd2;
    localparam t_cfg_idx CFG_PALIGN   = 4'd3;

    localparam logic [DW-1:0]  RST_WIN_BASE = 32'h6000_0000;
    localparam logic [DW-1:0]  RST_WIN_END  = 32'h7000_0000;
    localparam logic [ALW-1:0] RST_VALIGN   = 5'd25;
    localparam logic [ALW-1:0] RST_PALIGN   = 5'd16;

    typedef struct packed {
        logic accept;
        logic scan;
        logic exec;
    } t_dp_cmd;

    typedef struct packed {
        logic scan_done;
    } t_dp_sts;

endpackage

### hdl/vmrmt_if.sv
// ----------------------------------------------------------------------------
// vmrmt channel interfaces
// request, response and register write channels with valid/ready
// ----------------------------------------------------------------------------
interface vmrmt_req_if;
    import vmrmt_pkg::*;

    logic          valid;
    logic          ready;
    t_func         func;
    logic [DW-1:0] base_in;
    logic [DW-1:0] virt_size;
    logic [DW-1:0] phys_amount;

    modport source (output valid, func, base_in, virt_size, phys_amount, input ready);
    modport sink   (input valid, func, base_in, virt_size, phys_amount, output ready);
endinterface

interface vmrmt_rsp_if;
    import vmrmt_pkg::*;

    logic          valid;
    logic          ready;
    t_status       status;
    logic [DW-1:0] base_out;

    modport source (output valid, status, base_out, input ready);
    modport sink   (input valid, status, base_out, output ready);
endinterface

interface vmrmt_cfg_if;
    import vmrmt_pkg::*;

    logic          valid;
    logic          ready;
    t_cfg_idx      index;
    logic [DW-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

### hdl/vmrmt_ctrl.sv
// ----------------------------------------------------------------------------
// vmrmt_ctrl
// sequencer: accept, slot scan, execute, response register valid
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module vmrmt_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_req_valid,
    output logic              o_req_ready,
    output logic              o_rsp_valid,
    input  logic              i_rsp_ready,
    output vmrmt_pkg::t_dp_cmd o_cmd,
    input  vmrmt_pkg::t_dp_sts i_sts
);
    import vmrmt_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_EXEC = 2'd2;

    logic [1:0] r_state, n_state;
    logic       r_out_vld, n_out_vld;
    logic       acc;
    logic       out_free;

    assign acc      = (r_state == S_IDLE) && i_req_valid;
    assign out_free = !r_out_vld || i_rsp_ready;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (acc) n_state = S_SCAN;
            end
            S_SCAN: begin
                if (i_sts.scan_done) n_state = S_EXEC;
            end
            S_EXEC: begin
                if (out_free) n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd.accept = acc;
        o_cmd.scan   = (r_state == S_SCAN);
        o_cmd.exec   = (r_state == S_EXEC) && out_free;
    end

    assign n_out_vld = o_cmd.exec ? 1'b1 : (i_rsp_ready ? 1'b0 : r_out_vld);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_out_vld <= n_out_vld;
        end
    end

    assign o_req_ready = (r_state == S_IDLE);
    assign o_rsp_valid = r_out_vld;

    `VMRMT_ASSERT_NEXT(a_acc_to_scan, i_clk, i_rst_n, acc, r_state == S_SCAN)
    `VMRMT_ASSERT_NEXT(a_exec_result, i_clk, i_rst_n, o_cmd.exec, r_out_vld && r_state == S_IDLE)

endmodule

### hdl/vmrmt_dp.sv
// ----------------------------------------------------------------------------
// vmrmt_dp
// window registers, bump pointer, slot table and scan pipeline
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module vmrmt_dp #(
    parameter int SLOTS = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  vmrmt_pkg::t_cfg_idx          i_cfg_idx,
    input  logic [vmrmt_pkg::DW-1:0]     i_cfg_data,
    input  vmrmt_pkg::t_func             i_func,
    input  logic [vmrmt_pkg::DW-1:0]     i_base_in,
    input  logic [vmrmt_pkg::DW-1:0]     i_virt_size,
    input  logic [vmrmt_pkg::DW-1:0]     i_phys_amount,
    input  vmrmt_pkg::t_dp_cmd           i_cmd,
    output vmrmt_pkg::t_dp_sts           o_sts,
    output vmrmt_pkg::t_status           o_status,
    output logic [vmrmt_pkg::DW-1:0]     o_base_out
);
    import vmrmt_pkg::*;

    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    function automatic logic is_aligned(logic [DW-1:0] v, logic [ALW-1:0] lg);
        return (v & ~({DW{1'b1}} << lg)) == '0;
    endfunction

    // configuration and bump pointer
    logic [DW-1:0]  r_win_base, r_win_end, r_bump;
    logic [ALW-1:0] r_valign, r_palign;

    // current item
    t_func         r_func;
    logic [DW-1:0] r_base_in, r_virt, r_amt;

    // slot table
    logic          r_act      [SLOTS];
    logic [DW-1:0] r_mem_base [SLOTS];
    logic [DW-1:0] r_mem_phys [SLOTS];

    // scan pipeline
    logic          r_iss_on;
    logic [IW-1:0] r_iss_idx;
    logic          r_p_vld;
    logic [IW-1:0] r_p_idx;
    logic          r_p_act;
    logic [DW-1:0] r_rd_base, r_rd_phys;
    logic          r_found;
    logic [IW-1:0] r_hit_idx;
    logic [DW-1:0] r_hit_phys;

    // result
    t_status       r_status, n_status;
    logic [DW-1:0] r_base_out, n_base_out;

    logic          is_map;
    logic          p_hit, p_last;
    logic [DW-1:0] span;
    logic [DW:0]   end_sum;
    logic          amt_ok;
    logic          act_set, act_clr, base_we, phys_we, bump_we;
    logic [DW-1:0] phys_wdata;
    logic          map_ok;

    assign is_map = (r_func == FN_MAP);
    assign p_hit  = r_p_vld && (is_map ? !r_p_act : (r_p_act && r_rd_base == r_base_in));
    assign p_last = (r_p_idx == IW'(SLOTS - 1));
    assign o_sts.scan_done = r_p_vld && (p_hit || p_last);

    assign span    = (r_win_end >= r_win_base) ? (r_win_end - r_win_base) : '0;
    assign end_sum = {1'b0, r_bump} + {1'b0, r_virt};
    assign amt_ok  = (r_amt != '0) && is_aligned(r_amt, r_palign);

    always_comb begin
        n_status   = ST_INVAL;
        act_set    = 1'b0;
        act_clr    = 1'b0;
        base_we    = 1'b0;
        phys_we    = 1'b0;
        bump_we    = 1'b0;
        phys_wdata = r_amt;
        case (r_func)
            FN_MAP: begin
                if (r_virt == '0 || r_amt == '0 || !is_aligned(r_virt, r_valign) ||
                    !is_aligned(r_amt, r_palign) || r_virt > span) begin
                    n_status = ST_INVAL;
                end else if (end_sum > {1'b0, r_win_end} || !r_found) begin
                    n_status = ST_NOMEM;
                end else begin
                    n_status = ST_OK;
                    act_set  = 1'b1;
                    base_we  = 1'b1;
                    phys_we  = 1'b1;
                    bump_we  = 1'b1;
                end
            end
            FN_UNMAP: begin
                if (r_found) begin
                    n_status = ST_OK;
                    act_clr  = 1'b1;
                end
            end
            FN_APPEND: begin
                if (r_found && amt_ok) begin
                    n_status   = ST_OK;
                    phys_we    = 1'b1;
                    phys_wdata = r_hit_phys + r_amt;
                end
            end
            FN_RETURN: begin
                if (r_found && amt_ok && r_amt <= r_hit_phys) begin
                    n_status   = ST_OK;
                    phys_we    = 1'b1;
                    phys_wdata = r_hit_phys - r_amt;
                end
            end
            default: begin
                n_status = ST_INVAL;
            end
        endcase
    end

    assign n_base_out = (n_status == ST_OK && is_map) ? r_bump : '0;
    assign map_ok     = i_cmd.exec && is_map && n_status == ST_OK;

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win_base <= RST_WIN_BASE;
            r_win_end  <= RST_WIN_END;
            r_valign   <= RST_VALIGN;
            r_palign   <= RST_PALIGN;
            r_bump     <= RST_WIN_BASE;
            r_act      <= '{default: 1'b0};
            r_iss_on   <= 1'b0;
            r_p_vld    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_WIN_BASE: r_win_base <= i_cfg_data;
                    CFG_WIN_END:  r_win_end  <= i_cfg_data;
                    CFG_VALIGN:   r_valign   <= i_cfg_data[ALW-1:0];
                    CFG_PALIGN:   r_palign   <= i_cfg_data[ALW-1:0];
                    default: begin
                    end
                endcase
            end
            if (i_cmd.accept) begin
                r_iss_on <= 1'b1;
                r_p_vld  <= 1'b0;
            end else if (i_cmd.scan) begin
                r_p_vld <= r_iss_on;
                if (r_iss_on && r_iss_idx == IW'(SLOTS - 1)) r_iss_on <= 1'b0;
            end
            if (i_cmd.exec) begin
                if (act_set) r_act[r_hit_idx] <= 1'b1;
                if (act_clr) r_act[r_hit_idx] <= 1'b0;
                if (bump_we) r_bump <= end_sum[DW-1:0];
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_func    <= i_func;
            r_base_in <= i_base_in;
            r_virt    <= i_virt_size;
            r_amt     <= i_phys_amount;
            r_iss_idx <= '0;
        end else if (i_cmd.scan && r_iss_on) begin
            r_p_idx <= r_iss_idx;
            r_p_act <= r_act[r_iss_idx];
            if (r_iss_idx != IW'(SLOTS - 1)) r_iss_idx <= r_iss_idx + IW'(1);
        end
        if (i_cmd.scan && o_sts.scan_done) begin
            r_found    <= p_hit;
            r_hit_idx  <= r_p_idx;
            r_hit_phys <= r_rd_phys;
        end
        if (i_cmd.exec) begin
            r_status   <= n_status;
            r_base_out <= n_base_out;
        end
    end

    // slot table memories
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && base_we) r_mem_base[r_hit_idx] <= r_bump;
        if (i_cmd.exec && phys_we) r_mem_phys[r_hit_idx] <= phys_wdata;
        r_rd_base <= r_mem_base[r_iss_idx];
        r_rd_phys <= r_mem_phys[r_iss_idx];
    end

    assign o_status   = r_status;
    assign o_base_out = r_base_out;

    `VMRMT_ASSERT_NEXT(a_bump_step, i_clk, i_rst_n, map_ok, r_bump == $past(r_bump + r_virt))
    `VMRMT_ASSERT_NEXT(a_slot_taken, i_clk, i_rst_n, map_ok, r_act[$past(r_hit_idx)])

endmodule

### hdl/vm_region_mapping_table_unit.sv
// ----------------------------------------------------------------------------
// vm_region_mapping_table_unit
// slot table of virtual mappings with a bump pointer inside a window
// ----------------------------------------------------------------------------
// i_req carries one operation (map, unmap, append, return) per transfer;
// o_rsp returns one status and base per request, in order.
// i_cfg writes the window base, window end and the two alignment exponents;
// it is always ready and must be written only while no request is in flight;
// the unit does not enforce this. a request is taken only when the unit is
// idle. after the transfer the slot table is scanned one slot per cycle through
// the registered memory read, stopping at the first hit; then the unit executes
// and loads the response register. response valid is registered and rises as
// the unit returns to idle, where the next request can be taken; a new request
// is not taken before the last one has executed.
// reset clears all slot active bits, loads the reset window and sets the
// bump pointer to the window base. a stalled response holds in its register
// while the next request is still taken and scanned; execution waits until
// the response register is free.
// ----------------------------------------------------------------------------
module vm_region_mapping_table_unit #(
    parameter int SLOTS = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    vmrmt_cfg_if.sink    i_cfg,
    vmrmt_req_if.sink    i_req,
    vmrmt_rsp_if.source  o_rsp
);
    import vmrmt_pkg::*;

    t_dp_cmd cmd;
    t_dp_sts sts;
    logic    cfg_we;

    assign i_cfg.ready = 1'b1;
    assign cfg_we      = i_cfg.valid && i_cfg.ready;

    vmrmt_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .o_req_ready (i_req.ready),
        .o_rsp_valid (o_rsp.valid),
        .i_rsp_ready (o_rsp.ready),
        .o_cmd       (cmd),
        .i_sts       (sts)
    );

    vmrmt_dp #(
        .SLOTS (SLOTS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (cfg_we),
        .i_cfg_idx     (i_cfg.index),
        .i_cfg_data    (i_cfg.data),
        .i_func        (i_req.func),
        .i_base_in     (i_req.base_in),
        .i_virt_size   (i_req.virt_size),
        .i_phys_amount (i_req.phys_amount),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .o_status      (o_rsp.status),
        .o_base_out    (o_rsp.base_out)
    );

endmodule
